FILE: rtl/kdemux_pkg.sv
// Shared types and constants for the key-matching demultiplexer.
// Holds the request and result structs, operation and drop codes, and the
// configuration register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kdemux_pkg;

  // Block dimensions
  localparam int NUM_KEYS    = 4;
  localparam int NUM_FIELDS  = 4;
  localparam int VALUE_WIDTH = 32;
  localparam int NUM_PORTS   = NUM_KEYS + 1;
  localparam int TOTAL_W     = $clog2(NUM_PORTS + 1);

  // Operation codes
  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_UNBLOCK = 1'b1;

  // Drop reasons
  localparam logic [1:0] DROP_NONE         = 2'd0;
  localparam logic [1:0] DROP_ALL_BLOCKED  = 2'd1;
  localparam logic [1:0] DROP_DEST_BLOCKED = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_KEYS_IN_USE = 3'd0;
  localparam logic [2:0] CFG_MATCH_FIELD = 3'd1;
  localparam logic [2:0] CFG_KEY_ZERO    = 3'd2;
  localparam logic [2:0] CFG_KEY_ONE     = 3'd3;
  localparam logic [2:0] CFG_KEY_TWO     = 3'd4;
  localparam logic [2:0] CFG_KEY_THREE   = 3'd5;

  typedef struct packed {
    logic        operation;
    logic [31:0] field_zero;
    logic [31:0] field_one;
    logic [31:0] field_two;
    logic [31:0] field_three;
    logic [2:0]  unblock_port;
    logic        dest_accepts_more;
  } in_item_t;

  typedef struct packed {
    logic       forwarded;
    logic [2:0] dest_port;
    logic       input_ready;
    logic [1:0] drop_reason;
    logic       callback_held;
    logic       callback_overrun;
    logic       upstream_wakeup;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/key_demux_with_backpressure.sv
// Top level of the key-matching demultiplexer: request register, routing
// and blocking logic, result register and configuration registers.
// Depends on kdemux_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   in_valid/in_ready/in_data carry one request per accepted edge: either a
//   tuple push (field words plus a flag saying whether the chosen output
//   blocks afterwards) or an unblock of one output.
//   out_valid/out_ready/out_data return exactly one result per request:
//   routing decision, drop reason, readiness and wakeup flags.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the key count, the match
//   field selector and the four keys; cfg_ready is always high. Write
//   configuration only while no request is in flight.
// Pipeline and throughput
//   A request is registered on entry and moves into the result register
//   once that is free; out_valid rises as it moves, so a stalled result
//   holds it back. One request per cycle is sustained while out_ready is
//   high: the key compares, the priority pick and the blocked-mark update
//   all sit in the single stage between the request register and the
//   result register.
// Reset and stalls
//   rst (synchronous) clears all blocked marks, the blocked count and the
//   held wakeup, and restores keys_in_use to 4, match_field and keys to 0.
//   When out_ready is low the result register holds; the request register
//   still fills, and in_ready falls only when both are occupied.
module key_demux_with_backpressure
  import kdemux_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Configuration registers
  logic [2:0]                   keys_in_use;
  logic [1:0]                   match_field;
  logic [NUM_KEYS-1:0][31:0]    key_table;

  // Routing state
  logic [NUM_PORTS-1:0]         blocked_marks;
  logic [NUM_PORTS-1:0]         blocked_marks_next;
  logic [TOTAL_W-1:0]           blocked_total;
  logic [TOTAL_W-1:0]           blocked_total_next;
  logic                         wakeup_pending;
  logic                         wakeup_pending_next;

  // Request register
  logic                         req_valid;
  in_item_t                     req;
  logic                         advance;

  out_item_t                    res;
  logic [2:0]                   active;

  assign cfg_ready = 1'b1;

  // Advance the request into the result register whenever that is free
  assign advance  = !out_valid || out_ready;
  assign in_ready = !req_valid || advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      keys_in_use <= 3'd4;
      match_field <= 2'd0;
      key_table   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_KEYS_IN_USE) begin
        keys_in_use <= cfg_data[2:0];
      end
      if (cfg_index == CFG_MATCH_FIELD) begin
        match_field <= cfg_data[1:0];
      end
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (cfg_index == 3'(CFG_KEY_ZERO + i)) begin
          key_table[i] <= cfg_data;
        end
      end
    end
  end

  // Request register: hold while the result side stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req <= in_data;
    end
  end

  assign active = (keys_in_use > 3'(NUM_KEYS)) ? 3'(NUM_KEYS) : keys_in_use;

  // Route or unblock, and work out the next blocking state
  always_comb begin
    logic [1:0]             sel;
    logic [31:0]            value;
    logic [2:0]             dest;
    logic                   found;
    logic [TOTAL_W-1:0]     total_after;

    blocked_marks_next  = blocked_marks;
    blocked_total_next  = blocked_total;
    wakeup_pending_next = wakeup_pending;
    res                 = '0;
    res.input_ready     = 1'b1;
    res.drop_reason     = DROP_NONE;
    sel                 = (32'(match_field) >= 32'(NUM_FIELDS)) ?
                          2'(NUM_FIELDS - 1) : match_field;
    value               = req.field_zero;
    dest                = active;
    found               = 1'b0;
    total_after         = blocked_total;

    case (sel)
      2'd0:    value = req.field_zero;
      2'd1:    value = req.field_one;
      2'd2:    value = req.field_two;
      default: value = req.field_three;
    endcase

    // First matching key among the active ones wins
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (!found && (3'(i) < active) &&
          (key_table[i][VALUE_WIDTH-1:0] == value[VALUE_WIDTH-1:0])) begin
        dest  = 3'(i);
        found = 1'b1;
      end
    end

    if (req.operation == OP_UNBLOCK) begin
      // Clear one mark and fire any held wakeup
      if ((32'(req.unblock_port) < 32'(NUM_PORTS)) && blocked_marks[req.unblock_port]) begin
        blocked_marks_next[req.unblock_port] = 1'b0;
        if (blocked_total != '0) begin
          total_after = blocked_total - 1'b1;
        end
      end
      blocked_total_next  = total_after;
      res.upstream_wakeup = wakeup_pending;
      wakeup_pending_next = 1'b0;
      res.input_ready     = (total_after <= TOTAL_W'(active));
    end else if (blocked_total > TOTAL_W'(active)) begin
      // Every output blocked: drop and hold the upstream wakeup
      res.input_ready      = 1'b0;
      res.drop_reason      = DROP_ALL_BLOCKED;
      res.callback_overrun = wakeup_pending;
      res.callback_held    = !wakeup_pending;
      wakeup_pending_next  = 1'b1;
    end else begin
      res.dest_port = dest;
      if (blocked_marks[dest]) begin
        res.drop_reason = DROP_DEST_BLOCKED;
      end else begin
        res.forwarded = 1'b1;
        if (!req.dest_accepts_more) begin
          blocked_marks_next[dest] = 1'b1;
          total_after              = blocked_total + 1'b1;
          blocked_total_next       = total_after;
          if (total_after > TOTAL_W'(active)) begin
            res.input_ready      = 1'b0;
            res.callback_overrun = wakeup_pending;
            res.callback_held    = !wakeup_pending;
            wakeup_pending_next  = 1'b1;
          end
        end
      end
    end
  end

  // Commit state as the request moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      blocked_marks  <= '0;
      blocked_total  <= '0;
      wakeup_pending <= 1'b0;
    end else if (req_valid && advance) begin
      blocked_marks  <= blocked_marks_next;
      blocked_total  <= blocked_total_next;
      wakeup_pending <= wakeup_pending_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req_valid) begin
      out_data <= res;
    end
  end

  // Checks
  a_total_matches_marks: assert property (@(posedge clk) disable iff (rst)
    32'(blocked_total) == $countones(blocked_marks))
    else $error("blocked count differs from number of blocked marks");

  a_forward_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.forwarded) |-> (out_data.drop_reason == DROP_NONE))
    else $error("forwarded result carries a drop reason");

  a_held_sets_pending: assert property (@(posedge clk) disable iff (rst)
    (req_valid && advance && res.callback_held) |=> wakeup_pending)
    else $error("held wakeup not recorded");

  a_idle_state_stable: assert property (@(posedge clk) disable iff (rst)
    !req_valid |=> ($stable(blocked_marks) && $stable(wakeup_pending)))
    else $error("blocking state changed with no request");

endmodule

`default_nettype wire
